/* rtl/byte_ring_buffer_fifo_top_macros.svh */
// Assertion macros for the byte ring buffer FIFO.
// Used by rtl/brb_seq.sv; expects clk_i and rst_ni in scope.
`ifndef BYTE_RING_BUFFER_FIFO_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_FIFO_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BRB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define BRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/brb_pkg.sv */
// Shared types and constants for the byte ring buffer FIFO.
// No dependencies; imported by brb_seq and byte_ring_buffer_fifo_top.
`default_nettype none

package brb_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NB_W    = 4;
  localparam int unsigned LVL_W   = 11;
  localparam int unsigned ENQ_MAX = 8;
  localparam int unsigned BEAT_BYTES = 8;

  localparam logic [CMD_W-1:0] CMD_ENQ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NB_W-1:0]   nbytes;
    logic [DATA_W-1:0] rdata;
    logic              last;
    logic [LVL_W-1:0]  used;
    logic [LVL_W-1:0]  room;
  } beat_t;

endpackage

`default_nettype wire

/* rtl/byte_ring_buffer_fifo_top.sv */
// Byte ring buffer FIFO: AXI-stream style command in, result beats out.
// Depends on brb_pkg and brb_seq (which holds brb_mem).
//
// Slave channel carries one command per beat: tuser = cmd, tdata = count, data.
// Master channel returns result beats: tuser = status, tdata = nbytes, rdata,
// used, room; tlast marks the final beat of a command.
// Enqueue writes count bytes (0..8) at the tail, one byte per cycle, and
// returns one beat. Dequeue and peek read count bytes (0..READ_MAX) from the
// head in beats of 8 bytes, one byte per cycle through the storage read port
// while no beat waits. Skip, clear, refused and unknown commands return one beat.
// Flow: a command is taken only while the sequencer is idle, and each result
// beat is presented by the sequencer before moving to the output register.
// tready is low from acceptance until the last beat reaches the output register.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits behind it; a new command is taken while the last beat waits.
// Reset empties the queue (pointers and fill cleared); stored bytes are not.
`default_nettype none

module byte_ring_buffer_fifo_top #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned READ_MAX = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,   // cmd[2:0]
  input  wire logic [79:0] s_axis_tdata,   // count[10:0], data[74:11], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  output logic [95:0]      m_axis_tdata,   // nbytes[3:0], rdata[67:4], used[78:68],
                                           // room[89:79], zero pad
  output logic             m_axis_tlast
);
  import brb_pkg::*;

  logic  beat_valid;
  logic  beat_take;
  beat_t beat;
  beat_t out_q;
  logic  ovalid_q;

  brb_seq #(
    .CAPACITY (CAPACITY),
    .READ_MAX (READ_MAX)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .count_i      (s_axis_tdata[10:0]),
    .data_i       (s_axis_tdata[74:11]),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .beat_take_i  (beat_take)
  );

  assign beat_take = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (beat_take) begin
      ovalid_q <= beat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_take && beat_valid) begin
      out_q <= beat;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'd0, out_q.room, out_q.used, out_q.rdata, out_q.nbytes};

endmodule

`default_nettype wire

/* rtl/brb_mem.sv */
// Byte-wide storage of the ring buffer: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module brb_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/brb_seq.sv */
// Command sequencer of the ring buffer: checks, pointer updates and the
// byte-at-a-time read/write loop. Depends on brb_pkg, brb_mem and the macro header.
`default_nettype none

`include "byte_ring_buffer_fifo_top_macros.svh"

module brb_seq #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned READ_MAX = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [brb_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [brb_pkg::COUNT_W-1:0]   count_i,
  input  wire logic [brb_pkg::DATA_W-1:0]    data_i,
  output logic                               beat_valid_o,
  output brb_pkg::beat_t                     beat_o,
  input  wire logic                          beat_take_i
);
  import brb_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((FW > COUNT_W) ? FW : COUNT_W) + 1;
  localparam int unsigned RW = $clog2(READ_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] idx, logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(idx) + n;
    if (s >= CW'(CAPACITY)) begin
      s = s - CW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] idx);
    return (idx == AW'(CAPACITY - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [NB_W-1:0] beat_len(logic [RW-1:0] rem);
    return (rem >= RW'(BEAT_BYTES)) ? NB_W'(BEAT_BYTES) : NB_W'(rem);
  endfunction

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [NB_W-1:0]   nb_q, nb_d;
  logic [NB_W-1:0]   iss_q, iss_d;
  logic [NB_W-1:0]   got_q, got_d;
  logic              pend_q, pend_d;
  logic [NB_W-1:0]   wcnt_q, wcnt_d;
  logic [DATA_W-1:0] wdat_q, wdat_d;
  logic [DATA_W-1:0] word_q, word_d;
  logic [STAT_W-1:0] stat_q, stat_d;

  logic [FW-1:0]     room;
  logic [CW-1:0]     cnt_x;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_rdata;
  logic              accept;

  assign room       = FW'(CAPACITY) - fill_q;
  assign cnt_x      = CW'(count_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    nb_d    = nb_q;
    iss_d   = iss_q;
    got_d   = got_q;
    pend_d  = 1'b0;
    wcnt_d  = wcnt_q;
    wdat_d  = wdat_q;
    word_d  = word_q;
    stat_d  = stat_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          stat_d  = STAT_DONE;
          rem_d   = '0;
          nb_d    = '0;
          word_d  = '0;
          iss_d   = '0;
          got_d   = '0;
          state_d = ST_EMIT;
          unique case (cmd_i) inside
            CMD_ENQ: begin
              if (cnt_x > CW'(ENQ_MAX)) begin
                stat_d = STAT_LIMIT;
              end else if (cnt_x > CW'(room)) begin
                stat_d = STAT_SHORT;
              end else begin
                fill_d = fill_q + FW'(count_i);
                wcnt_d = NB_W'(count_i);
                wdat_d = data_i;
                if (count_i != '0) begin
                  state_d = ST_WRITE;
                end
              end
            end
            CMD_DEQ, CMD_PEEK: begin
              if (cnt_x > CW'(READ_MAX)) begin
                stat_d = STAT_LIMIT;
              end else if (cnt_x > CW'(fill_q)) begin
                stat_d = STAT_SHORT;
              end else begin
                pos_d = head_q;
                rem_d = RW'(count_i);
                nb_d  = beat_len(RW'(count_i));
                if (cmd_i == CMD_DEQ) begin
                  head_d = wrap_add(head_q, cnt_x);
                  fill_d = fill_q - FW'(count_i);
                end
                if (count_i != '0) begin
                  state_d = ST_READ;
                end
              end
            end
            CMD_SKIP: begin
              if (cnt_x > CW'(fill_q)) begin
                stat_d = STAT_SHORT;
              end else begin
                head_d = wrap_add(head_q, cnt_x);
                fill_d = fill_q - FW'(count_i);
              end
            end
            CMD_CLEAR: begin
              head_d = '0;
              tail_d = '0;
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        tail_d = wrap_inc(tail_q);
        wdat_d = wdat_q >> 8;
        wcnt_d = wcnt_q - NB_W'(1);
        if (wcnt_q == NB_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_READ: begin
        if (iss_q < nb_q) begin
          mem_re = 1'b1;
          pend_d = 1'b1;
          pos_d  = wrap_inc(pos_q);
          iss_d  = iss_q + NB_W'(1);
        end
        if (pend_q) begin
          word_d[{got_q[2:0], 3'b000} +: 8] = mem_rdata;
          got_d = got_q + NB_W'(1);
          rem_d = rem_q - RW'(1);
        end
        if (got_q == nb_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (beat_take_i) begin
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            nb_d    = beat_len(rem_q);
            iss_d   = '0;
            got_d   = '0;
            word_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
      nb_q    <= '0;
      iss_q   <= '0;
      got_q   <= '0;
      pend_q  <= 1'b0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      nb_q    <= nb_d;
      iss_q   <= iss_d;
      got_q   <= got_d;
      pend_q  <= pend_d;
      wcnt_q  <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdat_q <= wdat_d;
    word_q <= word_d;
    stat_q <= stat_d;
  end

  brb_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (wdat_q[7:0]),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  assign beat_valid_o  = (state_q == ST_EMIT);
  assign beat_o.status = stat_q;
  assign beat_o.nbytes = nb_q;
  assign beat_o.rdata  = word_q;
  assign beat_o.last   = (rem_q == '0);
  assign beat_o.used   = LVL_W'(fill_q);
  assign beat_o.room   = LVL_W'(room);

  logic [AW-1:0] tail_chk;
  assign tail_chk = wrap_add(head_q, CW'(fill_q));

  `BRB_ASSERT(a_fill_cap, fill_q <= FW'(CAPACITY), "fill exceeds capacity")
  `BRB_ASSERT_IMP(a_ptr_sync, state_q == ST_IDLE, tail_chk == tail_q, "head+fill != tail")
  `BRB_ASSERT_IMP(a_pend_read, pend_q, state_q == ST_READ, "read data pending outside read")
  `BRB_ASSERT_IMP(a_full_beat, beat_valid_o && !beat_o.last,
                  beat_o.nbytes == NB_W'(BEAT_BYTES), "short beat before last")
  `BRB_ASSERT_IMP(a_got_le_iss, state_q == ST_READ, got_q <= iss_q && iss_q <= nb_q,
                  "read counters out of order")

endmodule

`default_nettype wire

/* test/tb_byte_ring_buffer_fifo_top.sv */
// Self-checking testbench for byte_ring_buffer_fifo_top: directed and random command streams,
// with a byte-level ring model that predicts every result beat.
// Depends on brb_pkg and the RTL of byte_ring_buffer_fifo_top only.
`default_nettype none

module tb_byte_ring_buffer_fifo_top;
  import brb_pkg::*;

  localparam int unsigned CAP        = 1024;
  localparam int unsigned READ_LIMIT = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic [CMD_W-1:0] CMD_SPARE_MIN = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MAX = 3'd7;

  class ring_predictor;
    byte unsigned ring_mem[CAP];
    int unsigned  head;
    int unsigned  tail;
    int unsigned  fill;
    int unsigned  errors;
    beat_t        expected_beats[$];

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      errors = 0;
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void push_beat(logic [STAT_W-1:0] st, int unsigned nb, logic [DATA_W-1:0] word,
                            logic lst);
      beat_t b;
      b.status = st;
      b.nbytes = nb[NB_W-1:0];
      b.rdata  = word;
      b.last   = lst;
      b.used   = fill[LVL_W-1:0];
      b.room   = LVL_W'(CAP - fill);
      expected_beats.push_back(b);
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [COUNT_W-1:0] cnt,
                               logic [DATA_W-1:0] d);
      int unsigned n;
      int unsigned pos;
      int unsigned beats;
      int unsigned left;
      int unsigned nb;
      logic [DATA_W-1:0] word;
      n = 32'(cnt);
      case (op) inside
        CMD_ENQ: begin
          if (n > ENQ_MAX) begin
            push_beat(STAT_LIMIT, 0, '0, 1'b1);
          end else if (n > CAP - fill) begin
            push_beat(STAT_SHORT, 0, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) begin
              ring_mem[tail] = d[8*i +: 8];
              tail = (tail + 1) % CAP;
            end
            fill += n;
            push_beat(STAT_DONE, 0, '0, 1'b1);
          end
        end
        CMD_DEQ, CMD_PEEK: begin
          pos = head;
          if (n > READ_LIMIT) begin
            push_beat(STAT_LIMIT, 0, '0, 1'b1);
          end else if (n > fill) begin
            push_beat(STAT_SHORT, 0, '0, 1'b1);
          end else begin
            if (op == CMD_DEQ) begin
              head = (head + n) % CAP;
              fill -= n;
            end
            if (n == 0) begin
              push_beat(STAT_DONE, 0, '0, 1'b1);
            end else begin
              beats = (n + 7) / 8;
              for (int b = 0; b < beats; b++) begin
                left = n - b * 8;
                nb = left > 8 ? 8 : left;
                word = '0;
                for (int i = 0; i < nb; i++) begin
                  word[8*i +: 8] = ring_mem[pos];
                  pos = (pos + 1) % CAP;
                end
                push_beat(STAT_DONE, nb, word, b + 1 == beats);
              end
            end
          end
        end
        CMD_SKIP: begin
          if (n > fill) begin
            push_beat(STAT_SHORT, 0, '0, 1'b1);
          end else begin
            head = (head + n) % CAP;
            fill -= n;
            push_beat(STAT_DONE, 0, '0, 1'b1);
          end
        end
        CMD_CLEAR: begin
          head = 0;
          tail = 0;
          fill = 0;
          push_beat(STAT_DONE, 0, '0, 1'b1);
        end
        default: begin
          push_beat(STAT_DONE, 0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_beat(beat_t got);
      beat_t exp_b;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: status %0d nbytes %0d rdata %h", got.status,
               got.nbytes, got.rdata);
        errors++;
        return;
      end
      exp_b = expected_beats.pop_front();
      if (got.status !== exp_b.status) begin
        $error("status: expected %0d, got %0d", exp_b.status, got.status);
        errors++;
      end
      if (got.nbytes !== exp_b.nbytes) begin
        $error("nbytes: expected %0d, got %0d", exp_b.nbytes, got.nbytes);
        errors++;
      end
      if (got.rdata !== exp_b.rdata) begin
        $error("rdata: expected %h, got %h", exp_b.rdata, got.rdata);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $error("last: expected %0d, got %0d", exp_b.last, got.last);
        errors++;
      end
      if (got.used !== exp_b.used) begin
        $error("used: expected %0d, got %0d", exp_b.used, got.used);
        errors++;
      end
      if (got.room !== exp_b.room) begin
        $error("room: expected %0d, got %0d", exp_b.room, got.room);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;   // cmd[2:0]
  logic [79:0] s_axis_tdata = '0;   // count[10:0], data[74:11], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic [95:0] m_axis_tdata;        // nbytes[3:0], rdata[67:4], used[78:68], room[89:79]
  logic        m_axis_tlast;

  ring_predictor pred = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  byte_ring_buffer_fifo_top #(
    .CAPACITY(CAP),
    .READ_MAX(READ_LIMIT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  initial begin : result_sink
    int unsigned stall_left;
    beat_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.nbytes = m_axis_tdata[3:0];
        got.rdata  = m_axis_tdata[67:4];
        got.last   = m_axis_tlast;
        got.used   = m_axis_tdata[78:68];
        got.room   = m_axis_tdata[89:79];
        pred.check_beat(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 8) begin
        stall_left = $urandom_range(1, 4);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] op, logic [COUNT_W-1:0] cnt, logic [DATA_W-1:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, d, cnt};
    do @(posedge clk_i); while (!s_axis_tready);
    pred.note_command(op, cnt, d);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    int unsigned pick;
    int unsigned lim;
    int unsigned cnt;
    logic [CMD_W-1:0] op;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    d = {$urandom, $urandom};
    lim = pred.fill < READ_LIMIT ? pred.fill : READ_LIMIT;
    cnt = $urandom_range(0, 2047);
    if (pick < 40) begin
      op = CMD_ENQ;
      if ($urandom_range(0, 19) != 0) cnt = $urandom_range(0, ENQ_MAX);
    end else if (pick < 78) begin
      op = pick < 62 ? CMD_DEQ : CMD_PEEK;
      if ($urandom_range(0, 9) != 0) cnt = $urandom_range(0, lim);
    end else if (pick < 90) begin
      op = CMD_SKIP;
      if ($urandom_range(0, 9) != 0) cnt = $urandom_range(0, pred.fill < 40 ? pred.fill : 40);
    end else if (pick < 93) begin
      op = CMD_CLEAR;
    end else begin
      op = CMD_W'($urandom_range(CMD_SPARE_MIN, CMD_SPARE_MAX));
    end
    send_cmd(op, cnt[COUNT_W-1:0], d);
  endtask

  initial begin : stimulus
    int unsigned lim;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_DEQ, 11'd0, '0);
    send_cmd(CMD_PEEK, 11'd1, '0);
    send_cmd(CMD_SKIP, 11'd1, '0);
    send_cmd(CMD_SKIP, 11'd0, '0);
    send_cmd(CMD_ENQ, 11'd9, {$urandom, $urandom});
    send_cmd(CMD_ENQ, 11'd2047, '1);
    send_cmd(CMD_ENQ, 11'd0, {$urandom, $urandom});
    send_cmd(CMD_ENQ, 11'd8, '1);
    send_cmd(CMD_ENQ, 11'd8, '0);
    send_cmd(CMD_ENQ, 11'd5, {$urandom, $urandom});
    send_cmd(CMD_ENQ, 11'd8, {$urandom, $urandom});
    send_cmd(CMD_PEEK, 11'd8, '0);
    send_cmd(CMD_PEEK, 11'd29, '0);
    send_cmd(CMD_DEQ, 11'd3, '0);
    send_cmd(CMD_PEEK, 11'd64, '0);
    send_cmd(CMD_DEQ, 11'd65, '0);
    send_cmd(CMD_PEEK, 11'd2047, '1);
    send_cmd(CMD_SKIP, 11'd2, '0);
    send_cmd(CMD_SPARE_MIN, COUNT_W'($urandom_range(0, 2047)), {$urandom, $urandom});
    send_cmd(CMD_SPARE_MIN + 3'd1, COUNT_W'($urandom_range(0, 2047)), {$urandom, $urandom});
    send_cmd(CMD_SPARE_MAX, COUNT_W'($urandom_range(0, 2047)), {$urandom, $urandom});
    send_cmd(CMD_DEQ, 11'd24, '0);
    send_cmd(CMD_ENQ, 11'd3, {$urandom, $urandom});
    send_cmd(CMD_CLEAR, COUNT_W'($urandom_range(0, 2047)), {$urandom, $urandom});
    send_cmd(CMD_PEEK, 11'd1, '0);
    drain();

    // fill to capacity so the tail wraps; the sink holds off at the start of the fill
    idle_on = 1'b0;
    hold_req = 1'b1;
    while (pred.fill + ENQ_MAX <= CAP) begin
      if (pred.fill > 0 && $urandom_range(0, 9) == 0) begin
        lim = pred.fill < READ_LIMIT ? pred.fill : READ_LIMIT;
        send_cmd(CMD_PEEK, COUNT_W'($urandom_range(1, lim)), '0);
      end else begin
        send_cmd(CMD_ENQ, 11'd8, {$urandom, $urandom});
      end
    end
    idle_on = 1'b1;
    send_cmd(CMD_ENQ, COUNT_W'(CAP - pred.fill), {$urandom, $urandom});
    send_cmd(CMD_ENQ, 11'd1, {$urandom, $urandom});
    send_cmd(CMD_PEEK, 11'd64, '0);
    send_cmd(CMD_SKIP, COUNT_W'($urandom_range(900, 1010)), '0);

    repeat (70) random_cmd();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
